// File: rtl/mhfba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhfba_pkg: shared types and constants of the free-block allocator
// Heap geometry, per-level token and write-back items, RAM request bundle.
// ----------------------------------------------------------------------------
package mhfba_pkg;

  // Heap capacity and block number space
  localparam int HEAP_DEPTH = 1024;
  localparam int BLOCK_BITS = 32;

  // Fixed field widths
  localparam int ENTRY_W  = 32;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  // Derived geometry: one cell per heap level
  localparam int FILL_W    = $clog2(HEAP_DEPTH + 1);
  localparam int LVL_COUNT = $clog2(HEAP_DEPTH + 1);
  localparam int LVL_W     = $clog2(LVL_COUNT);
  localparam int IDX_W     = (LVL_COUNT - 1 > 2) ? LVL_COUNT - 1 : 2;
  localparam int ROW_W     = IDX_W - 1;
  localparam int CNT_W     = BLOCK_BITS + 1;

  localparam logic [CNT_W-1:0] BLK_LIMIT = CNT_W'(1) << BLOCK_BITS;

  // Operation codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOBLK   = 2'd3
  } status_t;

  typedef enum logic {
    K_INS = 1'b0,
    K_DEL = 1'b1
  } tok_kind_t;

  // Item walking down the level chain
  //   insert: idx is the path node at this level, path = position + 1,
  //           tgt = level where the new slot lives
  //   delete: idx is the hole index one level up, size = heap fill
  typedef struct packed {
    logic               valid;
    tok_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] carry;
    logic [FILL_W-1:0]  path;
    logic [FILL_W-1:0]  size;
    logic [LVL_W-1:0]   tgt;
  } tok_t;

  // Write-back from a cell into the level above it
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] data;
  } wb_t;

  // Direct entry read issued by the sequencer
  typedef struct packed {
    logic             en;
    logic [LVL_W-1:0] lvl;
    logic [IDX_W-1:0] idx;
  } probe_t;

  // Cell to level RAM request; a row holds two sibling entries
  typedef struct packed {
    logic [1:0]           wr_en;
    logic [ROW_W-1:0]     wr_row;
    logic [2*ENTRY_W-1:0] wr_data;
    logic                 rd_en;
    logic [ROW_W-1:0]     rd_row;
  } ram_req_t;

  typedef logic [LVL_COUNT-1:0][ENTRY_W-1:0] entry_vec_t;

  // Heap level of a position: floor(log2(p + 1))
  function automatic logic [LVL_W-1:0] lvl_of(input logic [FILL_W-1:0] p);
    logic [FILL_W-1:0] q;
    logic [LVL_W-1:0]  r;
    q = p + FILL_W'(1);
    r = '0;
    for (int b = 0; b < FILL_W; b++) begin
      if (q[b]) begin
        r = LVL_W'(b);
      end
    end
    return r;
  endfunction

  // Index of a position within its level
  function automatic logic [IDX_W-1:0] idx_of(input logic [FILL_W-1:0] p);
    logic [FILL_W-1:0] q;
    logic [LVL_W-1:0]  l;
    q = p + FILL_W'(1);
    l = lvl_of(p);
    return IDX_W'(q - (FILL_W'(1) << l));
  endfunction

  // Number of sibling-pair rows a level needs
  function automatic int level_rows(input int lvl);
    int cap;
    int ent;
    cap = 1 << lvl;
    ent = HEAP_DEPTH - (cap - 1);
    if (ent > cap) begin
      ent = cap;
    end
    return (ent + 1) >> 1;
  endfunction

endpackage

// File: rtl/mhfba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhfba_ram: storage of one heap level
// Rows of two sibling entries, per-entry write enables, registered read.
// ----------------------------------------------------------------------------
module mhfba_ram
  import mhfba_pkg::*;
#(
  parameter int ROWS = 2,
  parameter int AW   = 1
) (
  input  logic                 clk,
  input  logic [1:0]           wr_en,
  input  logic [AW-1:0]        wr_row,
  input  logic [2*ENTRY_W-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_row,
  output logic [2*ENTRY_W-1:0] rd_data
);

  logic [1:0][ENTRY_W-1:0] mem [ROWS];

  // Write either half of a row
  always_ff @(posedge clk) begin
    if (wr_en[0]) begin
      mem[wr_row][0] <= wr_data[ENTRY_W-1:0];
    end
    if (wr_en[1]) begin
      mem[wr_row][1] <= wr_data[2*ENTRY_W-1:ENTRY_W];
    end
  end

  // Registered read of a full row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

// File: rtl/mhfba_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhfba_cell: one heap level
// Takes an insert or delete item from the level above, compares against its
// own RAM, writes back upward and hands the item to the level below.
// ----------------------------------------------------------------------------
module mhfba_cell
  import mhfba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [LVL_W-1:0]     level,
  input  tok_t                 tok_in,
  output tok_t                 tok_out,
  input  wb_t                  wb_in,
  output wb_t                  wb_out,
  input  probe_t               probe,
  output logic [ENTRY_W-1:0]   entry,
  output logic                 done,
  output ram_req_t             ram_req,
  input  logic [2*ENTRY_W-1:0] ram_rdata
);

  typedef enum logic {
    C_IDLE = 1'b0,
    C_CMP  = 1'b1
  } cstate_t;

  cstate_t state;
  tok_t    tok_r;
  logic    half_r;

  logic [FILL_W-1:0]  base;
  logic [FILL_W-1:0]  in_lc;
  logic               in_leaf;
  logic               in_at_tgt;
  logic               probe_hit;
  logic [ENTRY_W-1:0] r_lo;
  logic [ENTRY_W-1:0] r_hi;
  logic [ENTRY_W-1:0] node;
  logic               ins_swap;
  logic [LVL_W-1:0]   path_sh;
  logic [FILL_W-1:0]  path_shifted;
  logic [FILL_W-1:0]  rc;
  logic               pick_hi;
  logic [ENTRY_W-1:0] pick;
  logic               del_stop;

  // Position arithmetic for this level
  assign base      = (FILL_W'(1) << level) - FILL_W'(1);
  assign in_lc     = base + FILL_W'({tok_in.idx, 1'b0});
  assign in_leaf   = in_lc >= tok_in.size;
  assign in_at_tgt = tok_in.tgt == level;
  assign probe_hit = probe.en && (probe.lvl == level);

  // Read data and compare stage
  assign r_lo         = ram_rdata[ENTRY_W-1:0];
  assign r_hi         = ram_rdata[2*ENTRY_W-1:ENTRY_W];
  assign node         = tok_r.idx[0] ? r_hi : r_lo;
  assign ins_swap     = tok_r.carry < node;
  assign path_sh      = tok_r.tgt - level - LVL_W'(1);
  assign path_shifted = tok_r.path >> path_sh;
  assign rc           = base + FILL_W'({tok_r.idx, 1'b0}) + FILL_W'(1);
  assign pick_hi      = (rc < tok_r.size) && !(r_lo < r_hi);
  assign pick         = pick_hi ? r_hi : r_lo;
  assign del_stop     = pick >= tok_r.carry;

  assign entry = half_r ? r_hi : r_lo;

  // RAM port control
  always_comb begin
    ram_req = '0;
    if (state == C_IDLE) begin
      if (tok_in.valid) begin
        if (tok_in.kind == K_INS) begin
          if (in_at_tgt) begin
            ram_req.wr_en   = tok_in.idx[0] ? 2'b10 : 2'b01;
            ram_req.wr_row  = tok_in.idx[IDX_W-1:1];
            ram_req.wr_data = {tok_in.carry, tok_in.carry};
          end else begin
            ram_req.rd_en  = 1'b1;
            ram_req.rd_row = tok_in.idx[IDX_W-1:1];
          end
        end else if (!in_leaf) begin
          // children of hole j sit together in row j
          ram_req.rd_en  = 1'b1;
          ram_req.rd_row = tok_in.idx[ROW_W-1:0];
        end
      end else if (wb_in.valid) begin
        ram_req.wr_en   = wb_in.idx[0] ? 2'b10 : 2'b01;
        ram_req.wr_row  = wb_in.idx[IDX_W-1:1];
        ram_req.wr_data = {wb_in.data, wb_in.data};
      end else if (probe_hit) begin
        ram_req.rd_en  = 1'b1;
        ram_req.rd_row = probe.idx[IDX_W-1:1];
      end
    end else if (tok_r.kind == K_INS && ins_swap) begin
      ram_req.wr_en   = tok_r.idx[0] ? 2'b10 : 2'b01;
      ram_req.wr_row  = tok_r.idx[IDX_W-1:1];
      ram_req.wr_data = {tok_r.carry, tok_r.carry};
    end
  end

  // Cell sequencing and handoff registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      tok_out <= '0;
      wb_out  <= '0;
      done    <= 1'b0;
    end else begin
      tok_out.valid <= 1'b0;
      wb_out.valid  <= 1'b0;
      done          <= 1'b0;
      case (state)
        C_IDLE: begin
          if (tok_in.valid) begin
            tok_r <= tok_in;
            if (tok_in.kind == K_INS) begin
              if (in_at_tgt) begin
                done <= 1'b1;
              end else begin
                state <= C_CMP;
              end
            end else if (in_leaf) begin
              // hole has no children: last entry lands in it
              wb_out.valid <= 1'b1;
              wb_out.idx   <= tok_in.idx;
              wb_out.data  <= tok_in.carry;
              done         <= 1'b1;
            end else begin
              state <= C_CMP;
            end
          end
          if (probe_hit) begin
            half_r <= probe.idx[0];
          end
        end
        C_CMP: begin
          state <= C_IDLE;
          if (tok_r.kind == K_INS) begin
            // keep the smaller value here, carry the larger one down
            tok_out.valid <= 1'b1;
            tok_out.kind  <= K_INS;
            tok_out.idx   <= IDX_W'({tok_r.idx, path_shifted[0]});
            tok_out.carry <= ins_swap ? node : tok_r.carry;
            tok_out.path  <= tok_r.path;
            tok_out.size  <= tok_r.size;
            tok_out.tgt   <= tok_r.tgt;
          end else if (del_stop) begin
            wb_out.valid <= 1'b1;
            wb_out.idx   <= tok_r.idx;
            wb_out.data  <= tok_r.carry;
            done         <= 1'b1;
          end else begin
            // smaller child moves up, hole moves down to it
            wb_out.valid  <= 1'b1;
            wb_out.idx    <= tok_r.idx;
            wb_out.data   <= pick;
            tok_out.valid <= 1'b1;
            tok_out.kind  <= K_DEL;
            tok_out.idx   <= IDX_W'({tok_r.idx, pick_hi});
            tok_out.carry <= tok_r.carry;
            tok_out.path  <= tok_r.path;
            tok_out.size  <= tok_r.size;
            tok_out.tgt   <= tok_r.tgt;
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/mhfba_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhfba_seq: item sequencer of the allocator
// Accepts items, keeps heap fill and the fresh block counter, reads the root
// and last entry, launches items into the level chain and issues results.
// ----------------------------------------------------------------------------
module mhfba_seq
  import mhfba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                op,
  input  logic [ENTRY_W-1:0]  block_number,
  output logic                busy,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  output probe_t              probe,
  input  entry_vec_t          entry_all,
  output tok_t                tok_ins,
  output tok_t                tok_del,
  input  logic                chain_done,
  output logic                done,
  output logic [ENTRY_W-1:0]  granted_block,
  output logic [STATUS_W-1:0] status,
  output logic                from_free_list,
  output logic [COUNT_W-1:0]  free_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_LAST,
    S_LAUNCH,
    S_WAIT
  } sstate_t;

  sstate_t            state;
  logic [FILL_W-1:0]  fill;
  logic [CNT_W-1:0]   next_blk;
  logic               forget;
  logic               op_r;
  logic [ENTRY_W-1:0] root_r;
  status_t            status_r;
  logic [LVL_W-1:0]   last_lvl;

  assign busy      = state != S_IDLE;
  assign cfg_ready = 1'b1;
  assign status    = status_r;
  assign last_lvl  = lvl_of(fill);

  // Item control, counters and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      fill           <= '0;
      next_blk       <= '0;
      forget         <= 1'b0;
      probe          <= '0;
      tok_ins        <= '0;
      tok_del        <= '0;
      done           <= 1'b0;
      granted_block  <= '0;
      status_r       <= ST_OK;
      from_free_list <= 1'b0;
      free_count     <= '0;
    end else begin
      probe.en      <= 1'b0;
      tok_ins.valid <= 1'b0;
      tok_del.valid <= 1'b0;
      done          <= 1'b0;
      if (cfg_valid) begin
        forget <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r           <= op;
            granted_block  <= '0;
            status_r       <= ST_OK;
            from_free_list <= 1'b0;
            free_count     <= COUNT_W'(fill);
            if (op == OP_ALLOC) begin
              if (fill != '0) begin
                fill      <= fill - FILL_W'(1);
                probe.en  <= 1'b1;
                probe.lvl <= '0;
                probe.idx <= '0;
                state     <= S_ROOT;
              end else if (next_blk == BLK_LIMIT) begin
                status_r <= ST_NOBLK;
                done     <= 1'b1;
              end else begin
                granted_block <= ENTRY_W'(next_blk);
                next_blk      <= next_blk + CNT_W'(1);
                done          <= 1'b1;
              end
            end else if (forget) begin
              status_r <= ST_IGNORED;
              done     <= 1'b1;
            end else if (fill >= FILL_W'(HEAP_DEPTH)) begin
              status_r <= ST_FULL;
              done     <= 1'b1;
            end else begin
              tok_ins.valid <= 1'b1;
              tok_ins.kind  <= K_INS;
              tok_ins.idx   <= '0;
              tok_ins.carry <= block_number;
              tok_ins.path  <= fill + FILL_W'(1);
              tok_ins.size  <= '0;
              tok_ins.tgt   <= lvl_of(fill);
              fill          <= fill + FILL_W'(1);
              state         <= S_WAIT;
            end
          end
        end
        S_ROOT: begin
          // root read in flight; fetch the last entry next
          probe.en  <= fill != '0;
          probe.lvl <= lvl_of(fill);
          probe.idx <= idx_of(fill);
          state     <= S_LAST;
        end
        S_LAST: begin
          root_r <= entry_all[0];
          if (fill == '0) begin
            granted_block  <= entry_all[0];
            from_free_list <= 1'b1;
            free_count     <= COUNT_W'(fill);
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          // last entry fills the root hole and sifts down from level one
          tok_del.valid <= 1'b1;
          tok_del.kind  <= K_DEL;
          tok_del.idx   <= '0;
          tok_del.carry <= entry_all[last_lvl];
          tok_del.path  <= '0;
          tok_del.size  <= fill;
          tok_del.tgt   <= '0;
          state         <= S_WAIT;
        end
        S_WAIT: begin
          if (chain_done) begin
            granted_block  <= (op_r == OP_ALLOC) ? root_r : '0;
            from_free_list <= op_r == OP_ALLOC;
            free_count     <= COUNT_W'(fill);
            done           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/min_heap_free_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_free_block_allocator_core: free block allocator on a min-heap
// Allocate takes the lowest released block or a fresh one; release inserts.
// Flow: counter grants and refused items finish in the cycle after accept;
//   a release walks the heap level by level down to its slot; an allocate
//   from the heap reads the root and the last entry, then the hole sinks
//   level by level, or it ends after those reads when the heap held one entry.
//   The heap has 11 levels. One item at a time; busy is high while an item walks the heap.
// Each level cell does a RAM read then a compare before it passes an item on.
// Reset: synchronous; clears heap fill, block counter and mode. Heap RAMs are
//   not cleared. done is a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module min_heap_free_block_allocator_core
  import mhfba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                op,
  input  logic [ENTRY_W-1:0]  block_number,
  output logic                done,
  output logic [ENTRY_W-1:0]  granted_block,
  output logic [STATUS_W-1:0] status,
  output logic                from_free_list,
  output logic [COUNT_W-1:0]  free_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  probe_t                 probe;
  entry_vec_t             entry_all;
  tok_t                   tok_ins;
  tok_t                   tok_del;
  tok_t                   tok_link [LVL_COUNT+1];
  tok_t                   tok_into [LVL_COUNT];
  wb_t                    wb_link  [LVL_COUNT+1];
  ram_req_t               ram_req  [LVL_COUNT];
  logic [2*ENTRY_W-1:0]   ram_rdata [LVL_COUNT];
  logic [LVL_COUNT-1:0]   cell_done;
  logic                   chain_done;

  assign chain_done = |cell_done;

  // Sequencer
  mhfba_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .op             (op),
    .block_number   (block_number),
    .busy           (busy),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .probe          (probe),
    .entry_all      (entry_all),
    .tok_ins        (tok_ins),
    .tok_del        (tok_del),
    .chain_done     (chain_done),
    .done           (done),
    .granted_block  (granted_block),
    .status         (status),
    .from_free_list (from_free_list),
    .free_count     (free_count)
  );

  // Chain ends: inserts enter at the root, nothing comes up past the bottom
  assign tok_link[0]         = tok_ins;
  assign wb_link[LVL_COUNT]  = '0;

  // One cell and one RAM per heap level
  for (genvar k = 0; k < LVL_COUNT; k++) begin : g_lvl
    localparam int ROWS_K = level_rows(k);
    localparam int AW_K   = (ROWS_K > 1) ? $clog2(ROWS_K) : 1;

    // deletes enter at level one, below the root hole
    if (k == 1) begin : g_del_in
      assign tok_into[k] = tok_link[k].valid ? tok_link[k] : tok_del;
    end else begin : g_pass_in
      assign tok_into[k] = tok_link[k];
    end

    mhfba_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .level     (LVL_W'(k)),
      .tok_in    (tok_into[k]),
      .tok_out   (tok_link[k+1]),
      .wb_in     (wb_link[k+1]),
      .wb_out    (wb_link[k]),
      .probe     (probe),
      .entry     (entry_all[k]),
      .done      (cell_done[k]),
      .ram_req   (ram_req[k]),
      .ram_rdata (ram_rdata[k])
    );

    mhfba_ram #(
      .ROWS (ROWS_K),
      .AW   (AW_K)
    ) u_ram (
      .clk     (clk),
      .wr_en   (ram_req[k].wr_en),
      .wr_row  (ram_req[k].wr_row[AW_K-1:0]),
      .wr_data (ram_req[k].wr_data),
      .rd_en   (ram_req[k].rd_en),
      .rd_row  (ram_req[k].rd_row[AW_K-1:0]),
      .rd_data (ram_rdata[k])
    );
  end

  // Checks
  a_done_not_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result issued while an item is still in the chain");

  a_one_finisher : assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_done))
    else $error("more than one level cell finished in the same cycle");

  a_no_fall_off : assert property (@(posedge clk) disable iff (rst)
    !tok_link[LVL_COUNT].valid)
    else $error("item passed below the last heap level");

  a_no_root_wb : assert property (@(posedge clk) disable iff (rst)
    !wb_link[0].valid)
    else $error("root cell issued a write-back above the root");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the min-heap free block allocator
// Drives allocate and release items through the start/busy port and keeps a
// private min-heap and block counter to work out each granted block, status,
// heap-source flag and free count. Every done strobe is compared with the
// oldest outstanding prediction. Covers counter grants, heap ordering with
// duplicates and extreme numbers, forget mode, a full heap and mixed traffic.
// ----------------------------------------------------------------------------
module tb;
  import mhfba_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 260;
  localparam int HEAP_TAKE     = 250;
  localparam int IDLE_PCT      = 29;
  localparam int MAX_REPORTS   = 10;

  // One predicted allocator response
  typedef struct {
    logic [ENTRY_W-1:0] granted;
    status_t            st;
    logic               from_heap;
    logic [COUNT_W-1:0] fill;
  } grant_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                op;
  logic [ENTRY_W-1:0]  block_number;
  logic                done;
  logic [ENTRY_W-1:0]  granted_block;
  logic [STATUS_W-1:0] status;
  logic                from_free_list;
  logic [COUNT_W-1:0]  free_count;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_data;

  // Shadow allocator state
  logic [ENTRY_W-1:0] heap_copy [HEAP_DEPTH];
  int unsigned        heap_len;
  logic [CNT_W-1:0]   fresh_next;
  logic               forget_mode;

  grant_t pending_grants [$];

  bit                 idle_on;
  logic [ENTRY_W-1:0] last_released;
  int                 stall_cycles = 0;
  int                 err_count = 0;
  int                 items_sent;
  int                 results_seen = 0;
  int                 n_from_heap;
  int                 n_from_counter;
  int                 n_ignored;
  int                 n_dropped;

  min_heap_free_block_allocator_core u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .block_number   (block_number),
    .done           (done),
    .granted_block  (granted_block),
    .status         (status),
    .from_free_list (from_free_list),
    .free_count     (free_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Remove the root; the last entry fills the hole and sinks
  function automatic logic [ENTRY_W-1:0] heap_take_lowest();
    logic [ENTRY_W-1:0] top;
    logic [ENTRY_W-1:0] last;
    int unsigned        hole;
    int unsigned        child;
    top = heap_copy[0];
    heap_len--;
    if (heap_len == 0) begin
      return top;
    end
    last = heap_copy[heap_len];
    hole = 0;
    while (1'b1) begin
      child = 2 * hole + 1;
      if (child >= heap_len) begin
        break;
      end
      // right child wins ties
      if (child + 1 < heap_len && heap_copy[child + 1] <= heap_copy[child]) begin
        child = child + 1;
      end
      if (heap_copy[child] >= last) begin
        break;
      end
      heap_copy[hole] = heap_copy[child];
      hole = child;
    end
    heap_copy[hole] = last;
    return top;
  endfunction

  // Append at the end and bubble up
  function automatic void heap_add(input logic [ENTRY_W-1:0] v);
    int unsigned hole;
    int unsigned up;
    hole = heap_len;
    heap_len++;
    while (hole != 0) begin
      up = (hole - 1) >> 1;
      if (heap_copy[up] < v) begin
        break;
      end
      heap_copy[hole] = heap_copy[up];
      hole = up;
    end
    heap_copy[hole] = v;
  endfunction

  // Response of the allocator to one item; updates the shadow state
  function automatic grant_t allocator_outcome(input logic o, input logic [ENTRY_W-1:0] num);
    grant_t r;
    r.granted   = '0;
    r.st        = ST_OK;
    r.from_heap = 1'b0;
    if (o == OP_ALLOC) begin
      if (heap_len != 0) begin
        r.granted   = heap_take_lowest();
        r.from_heap = 1'b1;
      end else if (fresh_next >= BLK_LIMIT) begin
        r.st = ST_NOBLK;
      end else begin
        r.granted  = fresh_next[ENTRY_W-1:0];
        fresh_next = fresh_next + 1'b1;
      end
    end else if (forget_mode) begin
      r.st = ST_IGNORED;
    end else if (heap_len >= HEAP_DEPTH) begin
      r.st = ST_FULL;
    end else begin
      heap_add(num);
    end
    r.fill = COUNT_W'(heap_len);
    return r;
  endfunction

  // Block numbers: wide random, small, near the top, repeats, extremes, one-hot
  function automatic logic [ENTRY_W-1:0] pick_block();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom();
      4, 5:       return $urandom_range(63);
      6:          return 32'hFFFF_FFFF - $urandom_range(63);
      7:          return last_released;
      8:          return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
      default:    return 32'h1 << $urandom_range(31);
    endcase
  endfunction

  // Present one item, hold it until accepted, then record the prediction
  task automatic send_item(input logic o, input logic [ENTRY_W-1:0] num);
    grant_t r;
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      start = 1'b0;
      @(negedge clk);
    end
    start        = 1'b1;
    op           = o;
    block_number = num;
    forever begin
      @(posedge clk);
      if (!busy) begin
        break;
      end
    end
    r = allocator_outcome(o, num);
    pending_grants.push_back(r);
    items_sent++;
    if (o == OP_RELEASE) begin
      last_released = num;
    end
    if (r.st == ST_IGNORED) begin
      n_ignored++;
    end else if (r.st == ST_FULL) begin
      n_dropped++;
    end else if (o == OP_ALLOC) begin
      if (r.from_heap) begin
        n_from_heap++;
      end else begin
        n_from_counter++;
      end
    end
  endtask

  // Stop sending and wait until every outstanding response is back
  task automatic drain_and_settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_grants.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mode register write, only with the block idle
  task automatic write_mode(input logic v);
    drain_and_settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    forever begin
      @(posedge clk);
      if (cfg_ready) begin
        break;
      end
    end
    forget_mode = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Counter grants, extreme and duplicate releases, heap ordering
  task automatic test_basic_grants();
    idle_on = 1'b0;
    repeat (3) send_item(OP_ALLOC, $urandom());
    send_item(OP_RELEASE, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, 32'h0000_0000);
    send_item(OP_RELEASE, 32'h8000_0000);
    send_item(OP_RELEASE, 32'h0000_0005);
    send_item(OP_RELEASE, 32'h7FFF_FFFF);
    send_item(OP_RELEASE, 32'h0000_0005);
    send_item(OP_RELEASE, 32'h0000_0001);
    repeat (8) send_item(OP_ALLOC, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, 32'hAAAA_AAAA);
    send_item(OP_RELEASE, 32'h5555_5555);
    send_item(OP_ALLOC, 32'h0);
  endtask

  // Releases are refused while forget mode is on; allocation still works
  task automatic test_forget_mode();
    write_mode(1'b1);
    idle_on = 1'b1;
    send_item(OP_RELEASE, 32'h0000_0009);
    send_item(OP_RELEASE, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_ALLOC, 32'h0);
    send_item(OP_RELEASE, 32'h0000_0000);
    write_mode(1'b0);
    send_item(OP_RELEASE, 32'h0000_0009);
    send_item(OP_ALLOC, 32'h0);
  endtask

  // Fill the heap to capacity, overflow it, then take part of it back in order
  task automatic test_heap_full();
    idle_on = 1'b1;
    while (heap_len < HEAP_DEPTH) begin
      send_item(OP_RELEASE, pick_block());
    end
    repeat (3) send_item(OP_RELEASE, pick_block());
    // mode wins over the full check
    write_mode(1'b1);
    send_item(OP_RELEASE, 32'h1234_5678);
    write_mode(1'b0);
    send_item(OP_RELEASE, 32'h0);
    drain_and_settle();
    repeat (HEAP_TAKE) begin
      send_item(OP_ALLOC, $urandom());
    end
  endtask

  // Bursts of release-heavy, allocate-heavy and mixed traffic
  task automatic test_mixed_traffic();
    int  sent;
    int  burst;
    int  rel_pct;
    bit  mode_done;
    bit  pause_done;
    sent       = 0;
    mode_done  = 1'b0;
    pause_done = 1'b0;
    idle_on    = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      // no sender gaps over the first stretch
      if (sent >= 100) begin
        idle_on = 1'b1;
      end
      burst = $urandom_range(1, 40);
      case ($urandom_range(2))
        0:       rel_pct = 80;
        1:       rel_pct = 20;
        default: rel_pct = 50;
      endcase
      repeat (burst) begin
        send_item(($urandom_range(99) < rel_pct) ? OP_RELEASE : OP_ALLOC, pick_block());
        sent++;
      end
      if (!pause_done && sent >= 150) begin
        drain_and_settle();
        pause_done = 1'b1;
      end
      if (!mode_done && sent >= 200) begin
        write_mode(1'b1);
        repeat (40) begin
          send_item($urandom_range(1) ? OP_RELEASE : OP_ALLOC, pick_block());
          sent++;
        end
        write_mode(1'b0);
        mode_done = 1'b1;
      end
    end
  endtask

  // Result checker: one prediction per done strobe
  always @(posedge clk) begin
    grant_t w;
    if (!rst && done) begin
      results_seen++;
      if (pending_grants.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("unexpected result: block %h status %0d heap %0b count %0d",
                   granted_block, status, from_free_list, free_count);
        end
      end else begin
        w = pending_grants.pop_front();
        if (granted_block !== w.granted || status !== w.st ||
            from_free_list !== w.from_heap || free_count !== w.fill) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("mismatch: block %h/%h status %0d/%0d heap %0b/%0b count %0d/%0d",
                     w.granted, granted_block, w.st, status,
                     w.from_heap, from_free_list, w.fill, free_count);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[min_heap_free_block_allocator_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    op             = OP_ALLOC;
    block_number   = '0;
    cfg_valid      = 1'b0;
    cfg_data       = 1'b0;
    idle_on        = 1'b0;
    last_released  = '0;
    heap_len       = 0;
    fresh_next     = '0;
    forget_mode    = 1'b0;
    items_sent     = 0;
    n_from_heap    = 0;
    n_from_counter = 0;
    n_ignored      = 0;
    n_dropped      = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_grants();
    test_forget_mode();
    test_heap_full();
    test_mixed_traffic();
    drain_and_settle();

    $display("Sent %0d items, checked %0d results: %0d heap grants, %0d counter grants,",
             items_sent, results_seen, n_from_heap, n_from_counter);
    $display("%0d releases refused in forget mode, %0d dropped on a full heap.",
             n_ignored, n_dropped);
    if (err_count == 0 && pending_grants.size() == 0) begin
      $display("[min_heap_free_block_allocator_core] OK");
    end else begin
      $display("[min_heap_free_block_allocator_core] ERROR");
    end
    $finish;
  end

endmodule
